@@ sv/nbm_pkg.sv @@
// ----------------------------------------------------------------------------
// nbm_pkg
// Shared types and codes for the nibble bank mapper with its IRQ down-counter.
// ----------------------------------------------------------------------------
package nbm_pkg;

	localparam logic [1:0] CMD_WRITE  = 2'd0;
	localparam logic [1:0] CMD_TICK   = 2'd1;
	localparam logic [1:0] CMD_INIT   = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_PRG  = 2'd1;
	localparam logic [1:0] KIND_CHR  = 2'd2;

	localparam logic [1:0] MIRROR_SINGLE_LO = 2'd2;

	localparam logic [2:0] IRQ_AT_ZERO      = 3'd0;
	localparam logic [2:0] IRQ_TOP_NIBBLE   = 3'd1;
	localparam logic [2:0] IRQ_TOP_BYTE     = 3'd2;
	localparam logic [2:0] IRQ_TOP_BYTE_ALT = 3'd3;

	localparam logic [15:0] ADDR_IRQ_RELOAD = 16'hF000;
	localparam logic [15:0] ADDR_IRQ_MODE   = 16'hF001;
	localparam logic [15:0] ADDR_MIRROR     = 16'hF002;

	localparam logic [3:0] PAGE_PRG_A = 4'h8;
	localparam logic [3:0] PAGE_PRG_B = 4'h9;
	localparam logic [3:0] PAGE_CHR_D = 4'hD;
	localparam logic [3:0] PAGE_LATCH = 4'hE;

	localparam int NUM_BANK_REGS = 11;
	localparam int BANK_IDX_W    = 4;
	localparam logic [BANK_IDX_W-1:0] FIRST_CHR_REG = 4'd3;

	localparam logic [8:0] ROM_BANKS_RESET = 9'd32;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] bus_addr;
		logic [7:0]  wr_data;
		logic [9:0]  cycles;
	} item_t;

	typedef struct packed {
		logic [1:0] map_kind;
		logic [2:0] map_slot;
		logic [7:0] map_bank;
		logic [1:0] mirror_mode;
		logic       irq_line;
		logic       last;
	} result_t;

	// first result word of an item plus what an init sequence needs later
	typedef struct packed {
		result_t    res;
		logic [7:0] bank_b2;
		logic [7:0] bank_b1;
	} core_out_t;

endpackage

@@ sv/nbm_core.sv @@
// ----------------------------------------------------------------------------
// nbm_core
// Register decode, bank/latch/IRQ state and the first result word of an item.
// ----------------------------------------------------------------------------
module nbm_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  nbm_pkg::item_t item,
	input  logic [8:0]     rom_banks_8k,
	output nbm_pkg::core_out_t core_out
);
	import nbm_pkg::*;

	logic [7:0]  bank_regs_q [NUM_BANK_REGS];
	logic [15:0] irq_reload_q;
	logic [15:0] irq_count_q;
	logic        irq_on_q;
	logic [2:0]  irq_sel_q;
	logic [1:0]  mirror_q;
	logic        irq_level_q;

	logic [3:0]  page;
	logic [11:0] low;
	logic        is_write;
	logic        bank_hit;
	logic        latch_hit;
	logic [1:0]  chr_pair;
	logic [BANK_IDX_W-1:0] reg_idx;
	logic [7:0]  bank_old;
	logic [7:0]  bank_new;
	logic [7:0]  b2;
	logic [7:0]  b1;

	logic [15:0] reload_d;
	logic [15:0] count_d;
	logic        on_d;
	logic [2:0]  sel_d;
	logic [1:0]  mirror_d;
	logic        level_d;

	logic [15:0] cyc16;
	logic [15:0] count_sub;
	logic        fire;

	assign page     = item.bus_addr[15:12];
	assign low      = item.bus_addr[11:0];
	assign is_write = (item.command == CMD_WRITE);
	assign bank_hit = is_write && (page >= PAGE_PRG_A) && (page <= PAGE_CHR_D)
		&& (low <= 12'd3) && !((page == PAGE_PRG_B) && low[1]);
	assign latch_hit = is_write && (page == PAGE_LATCH) && (low <= 12'd3);

	// A..D map to CHR pair 0..3
	assign chr_pair = page[1:0] - 2'd2;

	always_comb begin
		if (page == PAGE_PRG_A) begin
			reg_idx = {3'd0, low[1]};
		end else if (page == PAGE_PRG_B) begin
			reg_idx = 4'd2;
		end else begin
			reg_idx = FIRST_CHR_REG + {1'b0, chr_pair, low[1]};
		end
	end

	assign bank_old = (reg_idx < 4'(NUM_BANK_REGS)) ? bank_regs_q[reg_idx] : 8'd0;
	assign bank_new = low[0] ? {item.wr_data[3:0], bank_old[3:0]}
		: {bank_old[7:4], item.wr_data[3:0]};

	assign b2 = rom_banks_8k[7:0] - 8'd2;
	assign b1 = rom_banks_8k[7:0] - 8'd1;

	assign cyc16     = {6'd0, item.cycles};
	assign count_sub = irq_count_q - cyc16;

	always_comb begin
		case (irq_sel_q) inside
			IRQ_AT_ZERO:    fire = (cyc16 >= irq_count_q);
			IRQ_TOP_NIBBLE: fire = (count_sub[15:12] != irq_count_q[15:12]);
			[IRQ_TOP_BYTE:IRQ_TOP_BYTE_ALT]:
				fire = (count_sub[15:8] != irq_count_q[15:8]);
			default:        fire = (count_sub[15:4] != irq_count_q[15:4]);
		endcase
	end

	// next scalar state
	always_comb begin
		reload_d = irq_reload_q;
		count_d  = irq_count_q;
		on_d     = irq_on_q;
		sel_d    = irq_sel_q;
		mirror_d = mirror_q;
		level_d  = irq_level_q;
		case (item.command)
			CMD_WRITE: begin
				if (latch_hit) begin
					case (low[1:0])
						2'd0:    reload_d[3:0]   = item.wr_data[3:0];
						2'd1:    reload_d[7:4]   = item.wr_data[3:0];
						2'd2:    reload_d[11:8]  = item.wr_data[3:0];
						default: reload_d[15:12] = item.wr_data[3:0];
					endcase
				end else if (item.bus_addr == ADDR_IRQ_RELOAD) begin
					count_d = irq_reload_q;
				end else if (item.bus_addr == ADDR_IRQ_MODE) begin
					sel_d   = item.wr_data[3:1];
					on_d    = item.wr_data[0];
					level_d = 1'b0;
				end else if (item.bus_addr == ADDR_MIRROR) begin
					mirror_d = (item.wr_data[1:0] == 2'd3) ? MIRROR_SINGLE_LO
						: item.wr_data[1:0];
				end
			end
			CMD_TICK: begin
				if (irq_on_q && (irq_count_q != 16'd0)) begin
					if (fire) begin
						count_d = 16'd0;
						on_d    = 1'b0;
						level_d = 1'b1;
					end else begin
						count_d = count_sub;
					end
				end
			end
			CMD_INIT: begin
				reload_d = 16'hFFFF;
				count_d  = 16'hFFFF;
				on_d     = 1'b0;
				sel_d    = IRQ_AT_ZERO;
				level_d  = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BANK_REGS; i++) begin
				bank_regs_q[i] <= 8'd0;
			end
			irq_reload_q <= 16'hFFFF;
			irq_count_q  <= 16'hFFFF;
			irq_on_q     <= 1'b0;
			irq_sel_q    <= IRQ_AT_ZERO;
			mirror_q     <= 2'd0;
			irq_level_q  <= 1'b0;
		end else if (accept) begin
			irq_reload_q <= reload_d;
			irq_count_q  <= count_d;
			irq_on_q     <= on_d;
			irq_sel_q    <= sel_d;
			mirror_q     <= mirror_d;
			irq_level_q  <= level_d;
			if (item.command == CMD_INIT) begin
				for (int i = 0; i < NUM_BANK_REGS; i++) begin
					bank_regs_q[i] <= 8'd0;
				end
				bank_regs_q[2] <= b2;
				bank_regs_q[3] <= b1;
			end else if (bank_hit) begin
				bank_regs_q[reg_idx] <= bank_new;
			end
		end
	end

	always_comb begin
		core_out.res.map_kind    = KIND_NONE;
		core_out.res.map_slot    = 3'd0;
		core_out.res.map_bank    = 8'd0;
		core_out.res.mirror_mode = mirror_d;
		core_out.res.irq_line    = level_d;
		core_out.res.last        = 1'b1;
		core_out.bank_b2         = b2;
		core_out.bank_b1         = b1;
		if (item.command == CMD_INIT) begin
			core_out.res.map_kind = KIND_PRG;
			core_out.res.map_slot = 3'd4;
			core_out.res.last     = 1'b0;
		end else if (bank_hit) begin
			core_out.res.map_bank = bank_new;
			if (reg_idx < FIRST_CHR_REG) begin
				core_out.res.map_kind = KIND_PRG;
				core_out.res.map_slot = 3'd4 + reg_idx[2:0];
			end else begin
				core_out.res.map_kind = KIND_CHR;
				core_out.res.map_slot = 3'(reg_idx - FIRST_CHR_REG);
			end
		end
	end

endmodule

@@ sv/nibble_bank_mapper_with_irq_counter.sv @@
// ----------------------------------------------------------------------------
// nibble_bank_mapper_with_irq_counter
// Bank mapper with nibble-loaded bank registers and a 16-bit IRQ down-counter.
// ----------------------------------------------------------------------------
// The first result word of an accepted word is registered and shows in the cycle after it is accepted.
// Throughput: one word per cycle while result_stall is low; init produces four
// result words, so the result register holds the input off until the last is taken.
// Reset: arst_n clears banks, loads the IRQ latch and counter with all ones,
// and sets the program ROM bank count to 32.
module nibble_bank_mapper_with_irq_counter (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  nbm_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output nbm_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [8:0]       cfg_data
);
	import nbm_pkg::*;

	logic [8:0] rom_banks_q;
	core_out_t  core_out;
	logic       accept;
	logic       emit_done;

	result_t    res_q;
	logic       valid_q;
	logic [1:0] seq_idx_q;
	logic [7:0] b2_q;
	logic [7:0] b1_q;
	logic [1:0] seq_next;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_banks_q <= ROM_BANKS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			rom_banks_q <= cfg_data;
		end
	end

	// hold input while the result register is blocked or mid init sequence
	assign item_stall = valid_q && (result_stall || !res_q.last);
	assign accept     = item_valid && !item_stall;
	assign emit_done  = valid_q && !result_stall;
	assign seq_next   = seq_idx_q + 2'd1;

	nbm_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.item         (item),
		.rom_banks_8k (rom_banks_q),
		.core_out     (core_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			seq_idx_q <= 2'd0;
		end else if (accept) begin
			valid_q   <= 1'b1;
			seq_idx_q <= 2'd0;
		end else if (emit_done) begin
			if (res_q.last) begin
				valid_q <= 1'b0;
			end else begin
				seq_idx_q <= seq_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= core_out.res;
			b2_q  <= core_out.bank_b2;
			b1_q  <= core_out.bank_b1;
		end else if (emit_done && !res_q.last) begin
			// advance to the next PRG slot of the init sequence
			res_q.map_slot <= 3'd4 + {1'b0, seq_next};
			res_q.last     <= (seq_next == 2'd3);
			case (seq_next)
				2'd1:    res_q.map_bank <= 8'd1;
				2'd2:    res_q.map_bank <= b2_q;
				default: res_q.map_bank <= b1_q;
			endcase
		end
	end

	assign result_valid = valid_q;
	assign result       = res_q;

endmodule
